/* hw/rtl/rass_pkg.sv */
package rass_pkg;

    // Command codes carried in the cmd field
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_STOP_MS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_RESTART   = 3'd4;

    // Configuration reset values
    localparam logic [15:0] RST_DEBOUNCE_MS    = 16'd50;
    localparam logic [31:0] RST_AUTO_STOP_MS   = 32'd300000;
    localparam logic [15:0] RST_RETRY_INTERVAL = 16'd1000;
    localparam logic [7:0]  RST_MAX_RETRIES    = 8'd5;

    // Saturation point of the stop attempt counter
    localparam logic [7:0] ATTEMPT_MAX = 8'd255;

    // ms to seconds: q = (d * MUL) >> SHIFT is exact for any 32-bit d
    localparam int unsigned     DIV_MUL_W   = 29;
    localparam int unsigned     DIV_PROD_W  = 32 + DIV_MUL_W;
    localparam int unsigned     DIV_SHIFT   = 38;
    localparam int unsigned     SECS_W      = 23;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 29'd274877907;

    // Input item
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_ms;
        logic        arm_low;
        logic        start_ok;
        logic        stop_ok;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic              start_request;
        logic              stop_request;
        logic              mode;
        logic [SECS_W-1:0] recording_seconds;
        logic              command_ok;
    } t_out_item;

    // Sequencer decision for one item, before the seconds conversion
    typedef struct packed {
        logic        start_request;
        logic        stop_request;
        logic        mode;
        logic        command_ok;
        logic [31:0] elapsed_ms;
    } t_step;

endpackage

/* hw/rtl/rass_ctrl.sv */
module rass_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rass_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rass_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_accept,
    input  rass_pkg::t_in_item            i_item,
    output rass_pkg::t_step               o_step
);

    // Configuration registers
    logic [15:0] r_debounce_ms;
    logic [31:0] r_auto_stop_ms;
    logic [15:0] r_retry_interval;
    logic [7:0]  r_max_retries;
    logic        r_auto_restart;

    // Sequencer state
    logic        r_mode, n_mode;
    logic        r_arm_latched, n_arm_latched;
    logic [31:0] r_debounce_start, n_debounce_start;
    logic [31:0] r_record_start, n_record_start;
    logic [31:0] r_last_attempt, n_last_attempt;
    logic [7:0]  r_attempt_cnt, n_attempt_cnt;

    // Shared differences against the current time
    logic [31:0] w_deb_start;
    logic [31:0] w_deb_elapsed;
    logic [31:0] w_rec_elapsed;
    logic [31:0] w_retry_elapsed;
    logic [7:0]  w_attempt_inc;
    logic        w_retry_wait;
    logic        w_sreq, w_preq, w_ok;
    logic [1:0]  w_el_sel;

    localparam logic [1:0] EL_KEEP = 2'd0;
    localparam logic [1:0] EL_ZERO = 2'd1;
    localparam logic [1:0] EL_NOW  = 2'd2;

    assign w_deb_start     = (r_debounce_start == 32'd0) ? i_item.now_ms : r_debounce_start;
    assign w_deb_elapsed   = i_item.now_ms - w_deb_start;
    assign w_rec_elapsed   = i_item.now_ms - r_record_start;
    assign w_retry_elapsed = i_item.now_ms - r_last_attempt;
    assign w_retry_wait    = (r_last_attempt != 32'd0) &&
                             (w_retry_elapsed < {16'd0, r_retry_interval});
    assign w_attempt_inc   = (r_attempt_cnt < rass_pkg::ATTEMPT_MAX) ?
                             r_attempt_cnt + 8'd1 : r_attempt_cnt;

    // Next state and request decisions for the item at the input
    always_comb begin
        n_mode           = r_mode;
        n_arm_latched    = r_arm_latched;
        n_debounce_start = r_debounce_start;
        n_record_start   = r_record_start;
        n_last_attempt   = r_last_attempt;
        n_attempt_cnt    = r_attempt_cnt;
        w_sreq           = 1'b0;
        w_preq           = 1'b0;
        w_ok             = 1'b1;
        w_el_sel         = EL_KEEP;
        case (i_item.cmd)
            rass_pkg::CMD_TICK: begin
                if (!r_mode) begin
                    // idle: debounce the arm pin
                    if (!i_item.arm_low) begin
                        n_arm_latched    = 1'b0;
                        n_debounce_start = 32'd0;
                    end else if (!r_arm_latched) begin
                        n_debounce_start = w_deb_start;
                        if (w_deb_elapsed >= {16'd0, r_debounce_ms}) begin
                            n_arm_latched = 1'b1;
                            w_sreq        = 1'b1;
                            if (i_item.start_ok) begin
                                n_mode         = 1'b1;
                                n_record_start = i_item.now_ms;
                                w_el_sel       = EL_ZERO;
                            end
                        end
                    end
                end else if (w_rec_elapsed >= r_auto_stop_ms && !w_retry_wait) begin
                    // recording: automatic stop attempt
                    n_last_attempt = i_item.now_ms;
                    n_attempt_cnt  = w_attempt_inc;
                    w_preq         = 1'b1;
                    if (i_item.stop_ok) begin
                        n_last_attempt = 32'd0;
                        n_attempt_cnt  = 8'd0;
                        if (r_auto_restart) begin
                            w_sreq = 1'b1;
                            if (i_item.start_ok) begin
                                n_record_start = i_item.now_ms;
                                w_el_sel       = EL_ZERO;
                            end else begin
                                n_mode = 1'b0;
                            end
                        end else begin
                            n_mode           = 1'b0;
                            n_arm_latched    = 1'b0;
                            n_debounce_start = 32'd0;
                        end
                    end else if (w_attempt_inc >= r_max_retries) begin
                        // give up to idle
                        n_mode           = 1'b0;
                        n_arm_latched    = 1'b0;
                        n_debounce_start = 32'd0;
                        n_last_attempt   = 32'd0;
                        n_attempt_cnt    = 8'd0;
                    end
                end
            end
            rass_pkg::CMD_START: begin
                if (!r_mode) begin
                    w_sreq = 1'b1;
                    w_ok   = i_item.start_ok;
                    if (i_item.start_ok) begin
                        n_mode         = 1'b1;
                        n_record_start = 32'd0;
                        w_el_sel       = EL_NOW;
                    end
                end
            end
            rass_pkg::CMD_STOP: begin
                if (r_mode) begin
                    w_preq = 1'b1;
                    w_ok   = i_item.stop_ok;
                    if (i_item.stop_ok) begin
                        n_mode           = 1'b0;
                        n_arm_latched    = 1'b0;
                        n_debounce_start = 32'd0;
                    end
                end
            end
            default: begin
                // unused command: no action
            end
        endcase
    end

    // Decision handed to the result stage
    always_comb begin
        o_step.start_request = w_sreq;
        o_step.stop_request  = w_preq;
        o_step.mode          = n_mode;
        o_step.command_ok    = w_ok;
        case (w_el_sel)
            EL_ZERO: o_step.elapsed_ms = 32'd0;
            EL_NOW:  o_step.elapsed_ms = i_item.now_ms;
            default: o_step.elapsed_ms = w_rec_elapsed;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms    <= rass_pkg::RST_DEBOUNCE_MS;
            r_auto_stop_ms   <= rass_pkg::RST_AUTO_STOP_MS;
            r_retry_interval <= rass_pkg::RST_RETRY_INTERVAL;
            r_max_retries    <= rass_pkg::RST_MAX_RETRIES;
            r_auto_restart   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rass_pkg::REG_DEBOUNCE_MS:    r_debounce_ms    <= i_cfg_data[15:0];
                rass_pkg::REG_AUTO_STOP_MS:   r_auto_stop_ms   <= i_cfg_data[31:0];
                rass_pkg::REG_RETRY_INTERVAL: r_retry_interval <= i_cfg_data[15:0];
                rass_pkg::REG_MAX_RETRIES:    r_max_retries    <= i_cfg_data[7:0];
                rass_pkg::REG_AUTO_RESTART:   r_auto_restart   <= i_cfg_data[0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // Sequencer state, updated once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= 1'b0;
            r_arm_latched    <= 1'b0;
            r_debounce_start <= 32'd0;
            r_record_start   <= 32'd0;
            r_last_attempt   <= 32'd0;
            r_attempt_cnt    <= 8'd0;
        end else if (i_accept) begin
            r_mode           <= n_mode;
            r_arm_latched    <= n_arm_latched;
            r_debounce_start <= n_debounce_start;
            r_record_start   <= n_record_start;
            r_last_attempt   <= n_last_attempt;
            r_attempt_cnt    <= n_attempt_cnt;
        end
    end

`ifndef ASSERT_OFF
    // State only moves on an accepted item
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_mode) && $stable(r_attempt_cnt) && $stable(r_record_start))
        else $error("sequencer state changed without an item");

    // Successful force start from idle begins recording at time zero
    a_force_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.cmd == rass_pkg::CMD_START && !r_mode && i_item.start_ok)
        |=> r_mode && r_record_start == 32'd0)
        else $error("force start did not enter recording");

    // A successful stop either leaves recording or clears the retry count
    a_stop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_step.stop_request && i_item.stop_ok)
        |=> (!r_mode || r_attempt_cnt == 8'd0))
        else $error("successful stop left stale retry state");
`endif

endmodule

/* hw/rtl/record_arm_autostop_sequencer.sv */
// Channel | Direction | Handshake                    | Payload
// in      | input     | i_in_valid / o_in_ready      | i_in_data  (rass_pkg::t_in_item)
// out     | output    | o_out_valid / i_out_ready    | o_out_data (rass_pkg::t_out_item)
// cfg     | input     | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One item per cycle unless the output stalls; stage one feeds the output register.
// Sequencer state updates in the accept cycle; the ms to seconds multiply
// sits in the second stage ahead of the output register.
// i_rst_n is synchronous, active low; all control and state clear.
// A stalled output holds its item; the input keeps accepting while stage one
// is empty or can move forward. Config writes are always accepted.
module record_arm_autostop_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  rass_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output rass_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rass_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rass_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic                r_v1;
    rass_pkg::t_step     r_s1;
    logic                r_v2;
    rass_pkg::t_out_item r_out;

    rass_pkg::t_step                 w_step;
    logic                            w_accept;
    logic                            w_adv2;
    logic [rass_pkg::DIV_PROD_W-1:0] w_prod;
    rass_pkg::t_out_item             n_out;

    assign o_cfg_ready = 1'b1;
    assign w_adv2      = !r_v2 || i_out_ready;
    assign o_in_ready  = !r_v1 || w_adv2;
    assign w_accept    = i_in_valid && o_in_ready;

    rass_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_item      (i_in_data),
        .o_step      (w_step)
    );

    // Elapsed ms to whole seconds by reciprocal multiply
    assign w_prod = {{rass_pkg::DIV_MUL_W{1'b0}}, r_s1.elapsed_ms} *
                    {{32{1'b0}}, rass_pkg::DIV_MUL};

    always_comb begin
        n_out.start_request     = r_s1.start_request;
        n_out.stop_request      = r_s1.stop_request;
        n_out.mode              = r_s1.mode;
        n_out.command_ok        = r_s1.command_ok;
        n_out.recording_seconds = r_s1.mode ?
            w_prod[rass_pkg::DIV_SHIFT +: rass_pkg::SECS_W] : '0;
    end

    // Pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_accept) begin
                r_v1 <= 1'b1;
            end else if (w_adv2) begin
                r_v1 <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= w_step;
        end
        if (w_adv2 && r_v1) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_v2;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // An idle result never reports recording time
    a_idle_secs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.mode) |-> o_out_data.recording_seconds == '0)
        else $error("idle result with nonzero seconds");

    // An accepted item always lands in stage one
    a_stage1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_v1)
        else $error("accepted item lost before stage one");

    // A full stage one moves to the output when the output frees up
    a_stage2_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && w_adv2) |=> r_v2)
        else $error("stage one item not forwarded");
`endif

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int unsigned MS_PER_SEC  = 1000;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned LONG_HOLD   = 300;

    // DUT ports
    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_ready;
    rass_pkg::t_in_item              i_in_data   = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    rass_pkg::t_out_item             o_out_data;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [rass_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [rass_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Predicted sequencer state
    logic        rec_mode      = 1'b0;
    logic        arm_held      = 1'b0;
    logic [31:0] debounce_mark = '0;
    logic [31:0] rec_start     = '0;
    logic [31:0] last_try      = '0;
    logic [7:0]  try_count     = '0;

    // Predicted register settings
    logic [15:0] cfg_debounce  = rass_pkg::RST_DEBOUNCE_MS;
    logic [31:0] cfg_auto_stop = rass_pkg::RST_AUTO_STOP_MS;
    logic [15:0] cfg_retry     = rass_pkg::RST_RETRY_INTERVAL;
    logic [7:0]  cfg_max_tries = rass_pkg::RST_MAX_RETRIES;
    logic        cfg_restart   = 1'b0;

    // Bookkeeping
    rass_pkg::t_out_item pending_results[$];
    rass_pkg::t_out_item want;
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned stall_left     = 0;
    int unsigned hold_req       = 0;
    bit          idle_on        = 1'b1;
    logic [31:0] ms_now         = '0;

    record_arm_autostop_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Expected result of one item; advances the predicted state
    function automatic rass_pkg::t_out_item sequencer_step(input rass_pkg::t_in_item it);
        rass_pkg::t_out_item r;
        logic [31:0] since_mark;
        logic [31:0] since_start;
        logic [31:0] since_try;
        logic [31:0] secs;
        r = '0;
        r.command_ok = 1'b1;
        case (it.cmd)
            rass_pkg::CMD_TICK: begin
                if (!rec_mode) begin
                    if (!it.arm_low) begin
                        arm_held = 1'b0;
                        debounce_mark = '0;
                    end else if (!arm_held) begin
                        if (debounce_mark == 0) debounce_mark = it.now_ms;
                        since_mark = it.now_ms - debounce_mark;
                        if (since_mark >= {16'd0, cfg_debounce}) begin
                            arm_held = 1'b1;
                            r.start_request = 1'b1;
                            if (it.start_ok) begin
                                rec_mode = 1'b1;
                                rec_start = it.now_ms;
                            end
                        end
                    end
                end else begin
                    since_start = it.now_ms - rec_start;
                    since_try = it.now_ms - last_try;
                    // stop attempt once the run is long enough and back-off has passed
                    if (since_start >= cfg_auto_stop &&
                        (last_try == 0 || since_try >= {16'd0, cfg_retry})) begin
                        last_try = it.now_ms;
                        if (try_count != rass_pkg::ATTEMPT_MAX) try_count++;
                        r.stop_request = 1'b1;
                        if (it.stop_ok) begin
                            last_try = '0;
                            try_count = '0;
                            if (cfg_restart) begin
                                r.start_request = 1'b1;
                                if (it.start_ok) rec_start = it.now_ms;
                                else rec_mode = 1'b0;   // arm latch kept
                            end else begin
                                rec_mode = 1'b0;
                                arm_held = 1'b0;
                                debounce_mark = '0;
                            end
                        end else if (try_count >= cfg_max_tries) begin
                            rec_mode = 1'b0;
                            arm_held = 1'b0;
                            debounce_mark = '0;
                            last_try = '0;
                            try_count = '0;
                        end
                    end
                end
            end
            rass_pkg::CMD_START: begin
                if (!rec_mode) begin
                    r.start_request = 1'b1;
                    r.command_ok = it.start_ok;
                    if (it.start_ok) begin
                        rec_mode = 1'b1;
                        rec_start = '0;
                    end
                end
            end
            rass_pkg::CMD_STOP: begin
                if (rec_mode) begin
                    r.stop_request = 1'b1;
                    r.command_ok = it.stop_ok;
                    if (it.stop_ok) begin
                        rec_mode = 1'b0;
                        arm_held = 1'b0;
                        debounce_mark = '0;
                    end
                end
            end
            default: ;
        endcase
        r.mode = rec_mode;
        if (rec_mode) begin
            secs = (it.now_ms - rec_start) / MS_PER_SEC;
            r.recording_seconds = secs[rass_pkg::SECS_W-1:0];
        end
        return r;
    endfunction

    function automatic rass_pkg::t_in_item make_item(input logic [1:0] cmd,
                                                     input logic [31:0] now,
                                                     input logic arm, input logic sok,
                                                     input logic pok);
        rass_pkg::t_in_item it;
        it.cmd = cmd;
        it.now_ms = now;
        it.arm_low = arm;
        it.start_ok = sok;
        it.stop_ok = pok;
        return it;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 field, results_seen, got, exp_val);
        mismatch_count++;
    endtask

    // Offer one item, with an occasional gap first; predict on accept
    task automatic send_item(input rass_pkg::t_in_item it);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(sequencer_step(it));
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Wait until every result is back and the pipe is empty
    task automatic settle_block();
        release_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rass_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            rass_pkg::REG_DEBOUNCE_MS:    cfg_debounce = data[15:0];
            rass_pkg::REG_AUTO_STOP_MS:   cfg_auto_stop = data;
            rass_pkg::REG_RETRY_INTERVAL: cfg_retry = data[15:0];
            rass_pkg::REG_MAX_RETRIES:    cfg_max_tries = data[7:0];
            rass_pkg::REG_AUTO_RESTART:   cfg_restart = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] debounce, input logic [31:0] auto_stop,
                              input logic [15:0] retry, input logic [7:0] max_tries,
                              input logic restart);
        settle_block();
        write_reg(rass_pkg::REG_DEBOUNCE_MS, {16'd0, debounce});
        write_reg(rass_pkg::REG_AUTO_STOP_MS, auto_stop);
        write_reg(rass_pkg::REG_RETRY_INTERVAL, {16'd0, retry});
        write_reg(rass_pkg::REG_MAX_RETRIES, {24'd0, max_tries});
        write_reg(rass_pkg::REG_AUTO_RESTART, {31'd0, restart});
    endtask

    // Mostly well-formed time-ordered ticks, some force commands, a little noise
    task automatic run_traffic(input int count, input int unsigned step_max, input int hold_at);
        rass_pkg::t_in_item it;
        int unsigned        pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            ms_now += $urandom_range(0, step_max);
            it.cmd = (pick < 6) ? rass_pkg::CMD_START :
                     (pick < 12) ? rass_pkg::CMD_STOP : rass_pkg::CMD_TICK;
            it.now_ms = ms_now;
            it.arm_low = ($urandom_range(0, 9) != 0);
            it.start_ok = ($urandom_range(0, 4) != 0);
            it.stop_ok = ($urandom_range(0, 2) != 0);
            if (pick >= 97) begin
                it.cmd = 2'($urandom_range(0, 3));
                it.now_ms = $urandom();
            end
            send_item(it);
            if (n == hold_at) hold_req = LONG_HOLD;
        end
    endtask

    // Debounce, retries, give-up, force commands, time-zero marks, wrap, restart
    task automatic test_special_cases();
        set_config(16'd10, 32'd100, 16'd20, 8'd2, 1'b0);
        // mark at zero stays unset
        send_item(make_item(rass_pkg::CMD_TICK, 32'd0, 1'b1, 1'b0, 1'b0));
        send_item(make_item(rass_pkg::CMD_TICK, 32'd5, 1'b1, 1'b0, 1'b0));
        send_item(make_item(rass_pkg::CMD_TICK, 32'd15, 1'b1, 1'b0, 1'b1)); // arm, start fails
        send_item(make_item(rass_pkg::CMD_TICK, 32'd20, 1'b1, 1'b1, 1'b1)); // latched: nothing
        send_item(make_item(rass_pkg::CMD_TICK, 32'd21, 1'b0, 1'b1, 1'b1)); // pin released
        send_item(make_item(rass_pkg::CMD_TICK, 32'd30, 1'b1, 1'b1, 1'b0));
        send_item(make_item(rass_pkg::CMD_TICK, 32'd40, 1'b1, 1'b1, 1'b0)); // recording
        send_item(make_item(CMD_UNUSED, 32'd50, 1'b1, 1'b1, 1'b1));
        send_item(make_item(rass_pkg::CMD_START, 32'd60, 1'b1, 1'b0, 1'b0)); // no effect
        send_item(make_item(rass_pkg::CMD_TICK, 32'd140, 1'b1, 1'b1, 1'b0)); // first stop fails
        send_item(make_item(rass_pkg::CMD_TICK, 32'd150, 1'b1, 1'b1, 1'b1)); // inside back-off
        send_item(make_item(rass_pkg::CMD_TICK, 32'd160, 1'b1, 1'b1, 1'b0)); // gives up
        send_item(make_item(rass_pkg::CMD_STOP, 32'd170, 1'b1, 1'b0, 1'b0)); // no effect
        send_item(make_item(rass_pkg::CMD_START, 32'hFFFF_FFF0, 1'b0, 1'b0, 1'b1));
        send_item(make_item(rass_pkg::CMD_START, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0));
        send_item(make_item(rass_pkg::CMD_STOP, 32'h0000_1000, 1'b0, 1'b1, 1'b0));
        send_item(make_item(rass_pkg::CMD_STOP, 32'h0000_2000, 1'b0, 1'b0, 1'b1));

        set_config(16'd10, 32'd0, 16'd20, 8'd3, 1'b1);
        send_item(make_item(rass_pkg::CMD_TICK, 32'hFFFF_FFF8, 1'b1, 1'b0, 1'b0));
        send_item(make_item(rass_pkg::CMD_TICK, 32'd2, 1'b1, 1'b1, 1'b0)); // debounce across wrap
        // attempt stored as zero
        send_item(make_item(rass_pkg::CMD_TICK, 32'd0, 1'b1, 1'b1, 1'b0));
        // so retried at once
        send_item(make_item(rass_pkg::CMD_TICK, 32'd1, 1'b1, 1'b1, 1'b0));
        send_item(make_item(rass_pkg::CMD_TICK, 32'd5, 1'b1, 1'b1, 1'b1));
        send_item(make_item(rass_pkg::CMD_TICK, 32'd21, 1'b1, 1'b1, 1'b1)); // stop and restart
        send_item(make_item(rass_pkg::CMD_TICK, 32'd41, 1'b1, 1'b0, 1'b1)); // restart fails
        send_item(make_item(rass_pkg::CMD_TICK, 32'd50, 1'b1, 1'b1, 1'b1)); // latch kept

        set_config(16'd10, 32'd0, 16'd20, 8'd0, 1'b0);
        send_item(make_item(rass_pkg::CMD_START, 32'd100, 1'b0, 1'b1, 1'b0));
        // zero limit gives up
        send_item(make_item(rass_pkg::CMD_TICK, 32'd200, 1'b1, 1'b1, 1'b0));
    endtask

    task automatic test_nominal_traffic();
        set_config(16'd20, 32'd1500, 16'd200, 8'd3, 1'b0);
        ms_now = 32'd1;
        run_traffic(150, 60, -1);
    endtask

    task automatic test_low_extremes();
        set_config(16'd0, 32'd0, 16'd0, 8'd1, 1'b1);
        run_traffic(100, 5, -1);
    endtask

    task automatic test_high_extremes();
        set_config(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b0);
        ms_now = $urandom();
        run_traffic(60, 20000, -1);
    endtask

    task automatic test_reset_values_traffic();
        set_config(rass_pkg::RST_DEBOUNCE_MS, rass_pkg::RST_AUTO_STOP_MS,
                   rass_pkg::RST_RETRY_INTERVAL, rass_pkg::RST_MAX_RETRIES, 1'b0);
        ms_now = $urandom();
        run_traffic(100, 8000, -1);
    endtask

    // Receiver holds off for a long stretch early on so the block backs up
    task automatic test_output_backpressure();
        set_config(16'd5, 32'd400, 16'd50, 8'hFF, 1'b1);
        run_traffic(150, 40, 10);
    endtask

    task automatic test_back_to_back();
        set_config(16'd30, 32'd800, 16'd100, 8'd2, 1'b1);
        idle_on = 1'b0;
        run_traffic(300, 50, -1);
    endtask

    // Receiver: random stall bursts, plus the long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            stall_left = hold_req;
            hold_req = 0;
        end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14);
        end
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Result check against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 32'd0, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.start_request !== want.start_request)
                    report_mismatch("start_request", o_out_data.start_request,
                                    want.start_request);
                if (o_out_data.stop_request !== want.stop_request)
                    report_mismatch("stop_request", o_out_data.stop_request,
                                    want.stop_request);
                if (o_out_data.mode !== want.mode)
                    report_mismatch("mode", o_out_data.mode, want.mode);
                if (o_out_data.recording_seconds !== want.recording_seconds)
                    report_mismatch("recording_seconds", o_out_data.recording_seconds,
                                    want.recording_seconds);
                if (o_out_data.command_ok !== want.command_ok)
                    report_mismatch("command_ok", o_out_data.command_ok, want.command_ok);
            end
            results_seen++;
        end
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_special_cases();
        test_nominal_traffic();
        test_low_extremes();
        test_high_extremes();
        test_reset_values_traffic();
        test_output_backpressure();
        test_back_to_back();
        release_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/rass_pkg.sv
hw/rtl/rass_ctrl.sv
hw/rtl/record_arm_autostop_sequencer.sv
verif/tb_top.sv
